@@ rtl/core/positional_insert_queue_assert.svh @@
// Assertion macros used by the checker file.
`ifndef POSITIONAL_INSERT_QUEUE_ASSERT_SVH
`define POSITIONAL_INSERT_QUEUE_ASSERT_SVH

// Check a property on the rising clock, disabled while reset is low.
`define PIQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property on the rising clock, also during reset.
`define PIQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/piq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package piq_pkg;

  // Widest cell index: 11 bits address up to 2048 cells.
  localparam int IdxMaxW = 11;

  typedef enum logic [1:0] {
    KIND_APPEND    = 2'd0,
    KIND_PUSH_HEAD = 2'd1,
    KIND_INSERT_AT = 2'd2,
    KIND_POP_HEAD  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] value;
    logic        [7:0]  position;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] removed_value;
    logic        [6:0]  occupancy;
  } out_t;

  // Broadcast control from the queue front end to every cell.
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic [IdxMaxW-1:0] ins_idx;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/piq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One queue slot: holds, takes the new value, shifts toward the tail from
// its left neighbor, or shifts toward the head from its right neighbor.
module piq_cell #(
  parameter int IDX = 0
) (
  input  wire                      clk_i,
  input  wire piq_pkg::cell_ctrl_t ctrl_i,
  input  wire logic signed [31:0]  new_i,
  input  wire logic signed [31:0]  left_i,
  input  wire logic signed [31:0]  right_i,
  output logic signed [31:0]       value_o
);

  localparam logic [piq_pkg::IdxMaxW-1:0] MyIdx = piq_pkg::IdxMaxW'(IDX);

  logic signed [31:0] value_d, value_q;

  // Pick the next slot content
  always_comb begin
    value_d = value_q;
    priority if (ctrl_i.rem) begin
      value_d = right_i;
    end else if (ctrl_i.ins && (MyIdx == ctrl_i.ins_idx)) begin
      value_d = new_i;
    end else if (ctrl_i.ins && (MyIdx > ctrl_i.ins_idx)) begin
      value_d = left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

@@ rtl/core/positional_insert_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake              | Payload
// ----------+------------------------+----------------------------------
// request   | start_i / busy_o       | req_i  (kind, value, position)
// response  | valid_o (one cycle)    | rsp_o  (status, removed_value,
//           |                        |         occupancy)
//
// The whole row of cells shifts in parallel at the accepting edge, and
// the response shows in the following cycle.
// busy_o stays low, so an item may be started in every cycle.
// Reset clears the entry count; cell contents stay undefined until written.
// The receiver cannot stall; each response is valid for exactly one cycle.
module positional_insert_queue #(
  parameter int DEPTH = 64
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  output logic              busy_o,
  input  wire piq_pkg::in_t req_i,
  output logic              valid_o,
  output piq_pkg::out_t     rsp_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int CmpW = (CntW > 8) ? CntW : 8;

  logic [CntW-1:0]     count_d, count_q;
  logic                valid_q;
  piq_pkg::out_t       rsp_d, rsp_q;
  piq_pkg::cell_ctrl_t ctrl;
  logic                accept, is_full, is_empty;
  logic [CmpW-1:0]     pos_m1, cnt_ext, idx;
  logic signed [31:0]  cell_val [DEPTH];

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);

  // Work out the insert index
  assign pos_m1  = CmpW'(req_i.position - 8'd1);
  assign cnt_ext = CmpW'(count_q);

  always_comb begin
    idx = '0;
    unique case (req_i.kind)
      piq_pkg::KIND_APPEND: idx = cnt_ext;
      piq_pkg::KIND_INSERT_AT: begin
        if (req_i.position > 8'd1 && !is_empty) begin
          idx = (pos_m1 < cnt_ext) ? pos_m1 : cnt_ext;
        end
      end
      default: idx = '0;
    endcase
  end

  // Decide the operation and the response
  always_comb begin
    ctrl                = '0;
    ctrl.ins_idx        = piq_pkg::IdxMaxW'(idx);
    count_d             = count_q;
    rsp_d.status        = piq_pkg::ST_DONE;
    rsp_d.removed_value = '0;
    if (req_i.kind == piq_pkg::KIND_POP_HEAD) begin
      if (is_empty) begin
        rsp_d.status = piq_pkg::ST_EMPTY;
      end else begin
        ctrl.rem            = accept;
        rsp_d.removed_value = cell_val[0];
        count_d             = count_q - CntW'(1);
      end
    end else if (is_full) begin
      rsp_d.status = piq_pkg::ST_FULL;
    end else begin
      ctrl.ins = accept;
      count_d  = count_q + CntW'(1);
    end
    rsp_d.occupancy = 7'(count_d);
  end

  // Row of cells; each inner cell is wired to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = req_i.value;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    piq_cell #(.IDX(i)) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .new_i   (req_i.value),
      .left_i  (left_v),
      .right_i (right_v),
      .value_o (cell_val[i])
    );
  end

  // Hold count and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Capture the response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

`default_nettype wire

@@ rtl/core/piq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "positional_insert_queue_assert.svh"

module piq_checker #(
  parameter int DEPTH = 64
) (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                start_i,
  input wire                busy_o,
  input wire                valid_o,
  input wire piq_pkg::out_t rsp_o
);

  localparam logic [6:0] FullOcc = 7'(DEPTH);

  logic accept;
  assign accept = start_i && !busy_o;

  // Every accepted item gets one response in the next cycle, no other
  `PIQ_ASSERT(a_resp_follows, clk_i, rst_ni, accept |=> valid_o, "response missing")
  `PIQ_ASSERT(a_no_extra, clk_i, rst_ni, !accept |=> !valid_o, "spurious response")

  // A failed removal reports an empty queue and no value
  `PIQ_ASSERT(a_empty_resp, clk_i, rst_ni,
    valid_o && rsp_o.status == piq_pkg::ST_EMPTY |->
      rsp_o.removed_value == 0 && rsp_o.occupancy == 7'd0,
    "bad empty response")

  // A refused insert reports a full queue and no value
  `PIQ_ASSERT(a_full_resp, clk_i, rst_ni,
    valid_o && rsp_o.status == piq_pkg::ST_FULL |->
      rsp_o.removed_value == 0 && rsp_o.occupancy == FullOcc,
    "bad full response")

  // No strobe right after reset
  `PIQ_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !valid_o, "strobe after reset")

endmodule

bind positional_insert_queue piq_checker #(.DEPTH(DEPTH)) u_piq_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .valid_o (valid_o),
  .rsp_o   (rsp_o)
);

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import piq_pkg::*;

  localparam int          DEPTH      = 64;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int          RAND_ITEMS = 650;
  localparam int          SHOW_MAX   = 40;

  // Shadow of the queue contents plus the responses still owed by the block.
  class queue_tracker;
    int unsigned        depth;
    logic signed [31:0] held[$];
    out_t               owed_rsp[$];
    int unsigned        n_items, n_full, n_empty, peak;

    function new(int unsigned d);
      depth   = d;
      n_items = 0;
      n_full  = 0;
      n_empty = 0;
      peak    = 0;
    endfunction

    // Apply one operation to the shadow queue and return the response it earns.
    function out_t apply_op(in_t it);
      out_t        r;
      int unsigned slot;
      r.status        = ST_DONE;
      r.removed_value = '0;
      slot            = 0;
      if (it.kind == KIND_POP_HEAD) begin
        if (held.size() == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          r.removed_value = held.pop_front();
        end
      end else if (held.size() >= depth) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        case (it.kind)
          KIND_APPEND:    slot = held.size();
          KIND_PUSH_HEAD: slot = 0;
          default: begin
            // Front for position 0/1 or an empty queue; clamp past the end.
            if (it.position <= 1 || held.size() == 0) begin
              slot = 0;
            end else begin
              slot = it.position - 1;
              if (slot > held.size()) slot = held.size();
            end
          end
        endcase
        held.insert(slot, it.value);
      end
      r.occupancy = 7'(held.size());
      if (held.size() > peak) peak = held.size();
      return r;
    endfunction

    function void note_request(in_t it);
      owed_rsp.push_back(apply_op(it));
      n_items++;
    endfunction

    // Compare one response with the oldest one owed; describe any difference.
    function bit check_response(out_t got, output string why);
      out_t want;
      why = "";
      if (owed_rsp.size() == 0) begin
        why = "response with no item pending";
        return 1'b0;
      end
      want = owed_rsp.pop_front();
      if (got.status !== want.status)
        why = {why, $sformatf(" status got %0d want %0d;", got.status, want.status)};
      if (got.removed_value !== want.removed_value)
        why = {why, $sformatf(" removed_value got %h want %h;",
                              got.removed_value, want.removed_value)};
      if (got.occupancy !== want.occupancy)
        why = {why, $sformatf(" occupancy got %0d want %0d;",
                              got.occupancy, want.occupancy)};
      return (why == "");
    endfunction

    function int unsigned pending();
      return owed_rsp.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  in_t         req_i;
  logic        valid_o;
  out_t        rsp_o;

  queue_tracker tracker;
  int unsigned  errors;
  int unsigned  shown;
  int unsigned  cycles;

  positional_insert_queue #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    errors++;
    if (shown < SHOW_MAX) begin
      shown++;
      $display("[%0t] MISMATCH:%s", $realtime, msg);
    end
  endtask

  // Check the response first, then record the item accepted at this edge.
  always @(posedge clk_i) begin
    string why;
    if (rst_ni) begin
      if (valid_o) begin
        if (!tracker.check_response(rsp_o, why)) report_mismatch(why);
      end
      if (start_i && !busy_o) tracker.note_request(req_i);
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one item and hold it until the block takes it.
  task automatic send_item(in_t it);
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= it;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start and wait; n gives the length of the gap.
  task automatic idle(int unsigned n);
    if (n > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_t make_item(kind_e k, logic signed [31:0] v, logic [7:0] p);
    in_t it;
    it.kind     = k;
    it.value    = v;
    it.position = p;
    return it;
  endfunction

  // Random item; insert_pct sets how often it adds rather than removes.
  function automatic in_t rand_item(int unsigned insert_pct);
    in_t         it;
    int unsigned near;
    int unsigned vroll;
    if ($urandom_range(0, 99) < insert_pct)
      it.kind = kind_e'(2'($urandom_range(0, 2)));
    else
      it.kind = KIND_POP_HEAD;
    vroll = $urandom_range(0, 9);
    case (vroll)
      0:       it.value = 32'sh8000_0000;
      1:       it.value = 32'sh7fff_ffff;
      2:       it.value = '0;
      3:       it.value = -32'sd1;
      default: it.value = $urandom();
    endcase
    // Mostly positions around the current length, sometimes anywhere.
    near = tracker.held.size() + 2;
    if (near > 255) near = 255;
    if ($urandom_range(0, 99) < 70)
      it.position = 8'($urandom_range(0, near));
    else
      it.position = 8'($urandom_range(0, 255));
    return it;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase_len;
    int unsigned ins_pct;
    int unsigned mode;
    bit          no_gaps;
    bit          paused;

    tracker = new(DEPTH);
    errors  = 0;
    shown   = 0;
    cycles  = 0;
    start_i = 1'b0;
    req_i   = '0;
    rst_ni  = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty removal, front and end inserts, value extremes, drain.
    send_item(make_item(KIND_POP_HEAD,  32'sh5555_5555, 8'd0));
    send_item(make_item(KIND_INSERT_AT, 32'sh7fff_ffff, 8'd0));
    send_item(make_item(KIND_INSERT_AT, 32'sh8000_0000, 8'd200));
    send_item(make_item(KIND_PUSH_HEAD, -32'sd1,        8'd0));
    idle(2);
    send_item(make_item(KIND_APPEND,    32'sd0,         8'd255));
    send_item(make_item(KIND_INSERT_AT, 32'sd5,         8'd1));
    send_item(make_item(KIND_INSERT_AT, 32'sd6,         8'd2));
    send_item(make_item(KIND_INSERT_AT, 32'sd7,         8'd3));
    send_item(make_item(KIND_INSERT_AT, 32'shaaaa_aaaa, 8'd255));
    send_item(make_item(KIND_INSERT_AT, 32'sh0f0f_0f0f, 8'd10));
    idle(1);
    repeat (10) send_item(make_item(KIND_POP_HEAD, 32'shffff_ffff, 8'hff));

    // Random phases: fill toward full, drain toward empty, or mixed.
    sent   = 0;
    mode   = 0;
    paused = 1'b0;
    while (sent < RAND_ITEMS) begin
      if (sent == 0) mode = 0;
      else mode = $urandom_range(0, 2);
      case (mode)
        0:       ins_pct = 90;
        1:       ins_pct = 10;
        default: ins_pct = 50;
      endcase
      phase_len = (mode == 0) ? $urandom_range(80, 120) : $urandom_range(30, 90);
      if (phase_len > RAND_ITEMS - sent) phase_len = RAND_ITEMS - sent;
      no_gaps   = ($urandom_range(0, 99) < 30);
      repeat (phase_len) begin
        send_item(rand_item(ins_pct));
        sent++;
        if (!no_gaps) idle(pick_gap());
      end
      // Let the block run dry once mid-run.
      if (!paused && sent > RAND_ITEMS / 2) begin
        paused = 1'b1;
        @(negedge clk_i);
        start_i <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk_i);
      end
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("Covered %0d items: %0d refused as full, %0d removals from empty, peak %0d of %0d",
             tracker.n_items, tracker.n_full, tracker.n_empty, tracker.peak, DEPTH);
    $display("Mismatches counted: %0d", errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/piq_pkg.sv
rtl/core/piq_cell.sv
rtl/core/positional_insert_queue.sv
rtl/core/piq_checker.sv
verif/tb_top.sv
